FILE: rtl/equal_power_crossfade_mixer_assert.svh
// Assertion macros shared by the crossfade mixer RTL.
`ifndef EQUAL_POWER_CROSSFADE_MIXER_ASSERT_SVH
`define EQUAL_POWER_CROSSFADE_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPCM_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EPCM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/epcm_pkg.sv
// Shared constants, types and the gain table function of the crossfade mixer.
`timescale 1ns / 1ps

package epcm_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int CHANNELS    = 2;
	localparam int PHASE_STEPS = 1024;
	localparam int PHASE_BITS  = $clog2(PHASE_STEPS);
	localparam int POS_BITS    = 20;
	localparam int GAIN_BITS   = 16;
	localparam int K_BITS      = $clog2(PHASE_STEPS + 1);
	localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STEP_BITS   = $clog2(2 * CHANNELS + 1);

	typedef longint unsigned u64_t;

	localparam u64_t HalfPiQ30 = 64'd1686629713;
	localparam u64_t GainOne   = 64'd32768;
	localparam u64_t TaylorDiv [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic                          restart;
		logic signed [SAMPLE_BITS-1:0] old_left;
		logic signed [SAMPLE_BITS-1:0] old_right;
		logic signed [SAMPLE_BITS-1:0] new_left;
		logic signed [SAMPLE_BITS-1:0] new_right;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mix_left;
		logic signed [SAMPLE_BITS-1:0] mix_right;
		logic                          fading;
		logic                          fade_done;
	} mix_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROM_IN,
		ST_ROM_OUT,
		ST_MUL,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic               mul_en;
		logic               acc_first;
		logic               acc_last;
		logic [CH_BITS-1:0] ch;
	} mac_ctrl_t;

	// Q1.15 sine gain for phase step k, from a Taylor series in Q2.30.
	// Only evaluated at elaboration to fill the gain table.
	function automatic logic [GAIN_BITS-1:0] sine_gain(input int k);
		u64_t x;
		u64_t term;
		u64_t sum;
		x    = (u64_t'(k) * HalfPiQ30) / PHASE_STEPS;
		term = x;
		sum  = x;
		for (int n = 1; n <= 6; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / TaylorDiv[n];
			if (n % 2 == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		sum = (sum + 64'd16384) >> 15;
		if (sum > GainOne) begin
			sum = GainOne;
		end
		return sum[GAIN_BITS-1:0];
	endfunction

endpackage

FILE: rtl/epcm_stream_if.sv
// Valid/ready stream interface that carries one word per handshake.
`timescale 1ns / 1ps

interface epcm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/equal_power_crossfade_mixer.sv
// Top level of the equal-power crossfade mixer.
`timescale 1ns / 1ps
//
// The mixer takes one stereo frame per word on the frame channel: the samples
// of the outgoing chain, those of the incoming chain and a restart flag. It
// returns one word per frame on the mix channel with the mixed samples and
// the fading and fade_done flags. A set restart flag starts a new crossfade
// at position zero with that frame; the fade lasts fade_length frames, which
// software writes through cfg_we / cfg_wdata while the mixer is idle.
//
// A fading frame passes from acceptance through the iterative phase divider
// (one quotient bit per cycle; a position that has reached the length skips
// the division), two gain table reads and the shared multiplier, and then its
// word is loaded into the output register. Outside a fade the word is loaded
// without the divider, table or multiplier. frame.ready is high only in idle,
// so a new frame is accepted only once the last one's word has been loaded.
//
// The output register decouples the two sides: a new frame is accepted while
// the previous result still waits to be taken. If the receiver stalls, the
// finished result of the next frame waits in the sequencer until the output
// register frees. Reset clears the fade state, sets fade_length to one and
// empties the output register.

`include "equal_power_crossfade_mixer_assert.svh"

module equal_power_crossfade_mixer import epcm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [POS_BITS-1:0] cfg_wdata,
	epcm_stream_if.sink         frame,
	epcm_stream_if.source       mix
);

	state_t state_q;
	state_t state_d;

	// Fade state and the one configuration register.
	logic [POS_BITS-1:0] fade_length_q;
	logic [POS_BITS-1:0] pos_q;
	logic                active_q;

	// The frame being worked on and its flags.
	frame_t frame_q;
	logic   fading_q;
	logic   done_q;

	logic [STEP_BITS-1:0] step_q;
	logic [GAIN_BITS-1:0] g_in_q;
	logic                 out_valid_q;
	mix_t                 out_q;

	frame_t              in_word;
	logic                in_fire;
	logic [POS_BITS-1:0] len;
	logic [POS_BITS-1:0] pos_eff;
	logic [POS_BITS-1:0] pos_inc;
	logic                active_eff;
	logic                ends;
	logic                load_out;

	div_ctrl_t            div_ctrl;
	div_stat_t            div_stat;
	logic [K_BITS-1:0]    k;
	logic [K_BITS-1:0]    rom_addr;
	logic [GAIN_BITS-1:0] rom_data;
	mac_ctrl_t            mac_ctrl;
	sample_t              mac_smp;
	logic [GAIN_BITS-1:0] mac_gain;
	sample_t              mac_res [CHANNELS];
	sample_t              old_smp [CHANNELS];
	sample_t              new_smp [CHANNELS];
	logic [STEP_BITS-1:0] step_prev;
	logic [CH_BITS-1:0]   mul_ch;

	assign in_word = frame.payload;
	assign in_fire = frame.valid && frame.ready;

	// A length of zero behaves as a one-frame fade.
	assign len = (fade_length_q == '0) ? POS_BITS'(1) : fade_length_q;

	// A restart takes effect on the frame that carries it.
	assign pos_eff    = in_word.restart ? '0 : pos_q;
	assign active_eff = in_word.restart || active_q;
	assign pos_inc    = pos_eff + POS_BITS'(1);
	assign ends       = pos_inc >= len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_length_q <= POS_BITS'(1);
			pos_q         <= '0;
			active_q      <= 1'b0;
			fading_q      <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				fade_length_q <= cfg_wdata;
			end
			if (in_fire) begin
				fading_q <= active_eff;
				done_q   <= active_eff && ends;
				if (active_eff) begin
					if (ends) begin
						active_q <= 1'b0;
						pos_q    <= '0;
					end else begin
						active_q <= 1'b1;
						pos_q    <= pos_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			frame_q <= in_word;
		end
		if (state_q == ST_ROM_OUT) begin
			g_in_q <= rom_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == ST_MUL) ? step_q + STEP_BITS'(1) : '0;
		end
	end

	// The multiplier works through old*gOut and new*gIn for each channel in
	// turn; the accumulator side trails it, working on the registered product.
	assign old_smp[0] = frame_q.old_left;
	assign old_smp[1] = frame_q.old_right;
	assign new_smp[0] = frame_q.new_left;
	assign new_smp[1] = frame_q.new_right;

	assign step_prev = step_q - STEP_BITS'(1);
	assign mul_ch    = step_q[CH_BITS:1];
	assign mac_smp   = step_q[0] ? new_smp[mul_ch] : old_smp[mul_ch];
	assign mac_gain  = step_q[0] ? g_in_q : rom_data;

	always_comb begin
		state_d            = state_q;
		frame.ready        = 1'b0;
		div_ctrl.start     = 1'b0;
		mac_ctrl.mul_en    = 1'b0;
		mac_ctrl.acc_first = 1'b0;
		mac_ctrl.acc_last  = 1'b0;
		mac_ctrl.ch        = step_prev[CH_BITS:1];
		rom_addr           = K_BITS'(PHASE_STEPS) - k;
		load_out           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					if (active_eff) begin
						div_ctrl.start = 1'b1;
						state_d        = ST_DIV;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_ROM_IN;
				end
			end
			ST_ROM_IN: begin
				rom_addr = k;
				state_d  = ST_ROM_OUT;
			end
			ST_ROM_OUT: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				mac_ctrl.mul_en = step_q < STEP_BITS'(2 * CHANNELS);
				if (step_q != '0) begin
					mac_ctrl.acc_first = !step_prev[0];
					mac_ctrl.acc_last  = step_prev[0];
				end
				if (step_q == STEP_BITS'(2 * CHANNELS)) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!out_valid_q || mix.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (mix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.mix_left  <= fading_q ? mac_res[0] : frame_q.new_left;
			out_q.mix_right <= fading_q ? mac_res[1] : frame_q.new_right;
			out_q.fading    <= fading_q;
			out_q.fade_done <= done_q;
		end
	end

	assign mix.valid   = out_valid_q;
	assign mix.payload = out_q;

	epcm_phase_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.pos    (pos_eff),
		.len    (len),
		.stat   (div_stat),
		.k      (k)
	);

	epcm_gain_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	epcm_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.smp  (mac_smp),
		.gain (mac_gain),
		.res  (mac_res)
	);

	// A restart frame is always mixed as part of a fade.
	`EPCM_ASSERT_NEXT(a_restart_fades, clk, arst_n, in_fire && in_word.restart, fading_q, "restart frame not marked as fading")
	// Outside a fade the position rests at zero.
	`EPCM_ASSERT_IMPLY(a_idle_pos_zero, clk, arst_n, !active_q, pos_q == '0, "fade position not cleared")
	// The phase step never passes the end of the gain table.
	`EPCM_ASSERT_IMPLY(a_phase_range, clk, arst_n, div_stat.done, k <= K_BITS'(PHASE_STEPS), "phase step out of range")
	// The multiplier only runs for a frame that is fading.
	`EPCM_ASSERT_IMPLY(a_mul_only_fading, clk, arst_n, state_q == ST_MUL, fading_q, "multiplier used outside a fade")

endmodule

FILE: rtl/epcm_phase_div.sv
// Iterative divider giving the fade phase step floor(pos * PHASE_STEPS / len).
`timescale 1ns / 1ps

module epcm_phase_div import epcm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  div_ctrl_t           ctrl,
	input  logic [POS_BITS-1:0] pos,
	input  logic [POS_BITS-1:0] len,
	output div_stat_t           stat,
	output logic [K_BITS-1:0]   k
);

	localparam int CNT_BITS = $clog2(PHASE_BITS + 1);

	logic                  busy_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  over_q;
	logic [POS_BITS-1:0]   rem_q;
	logic [PHASE_BITS-1:0] quo_q;

	logic [POS_BITS:0] shifted;
	logic [POS_BITS:0] diff;
	logic              fits;

	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, len};
	assign fits    = shifted >= {1'b0, len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= (pos >= len) ? '0 : CNT_BITS'(PHASE_BITS);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// One quotient bit per cycle; while dividing, the remainder stays below len.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			over_q <= pos >= len;
			rem_q  <= pos;
			quo_q  <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fits ? diff[POS_BITS-1:0] : shifted[POS_BITS-1:0];
			quo_q <= {quo_q[PHASE_BITS-2:0], fits};
		end
	end

	assign stat.done = busy_q && (cnt_q == '0);
	assign k         = over_q ? K_BITS'(PHASE_STEPS) : K_BITS'(quo_q);

endmodule

FILE: rtl/epcm_gain_rom.sv
// Constant sine gain table with a registered read port.
`timescale 1ns / 1ps

module epcm_gain_rom import epcm_pkg::*; (
	input  logic                 clk,
	input  logic [K_BITS-1:0]    addr,
	output logic [GAIN_BITS-1:0] data
);

	logic [GAIN_BITS-1:0] gain_tbl [PHASE_STEPS+1];
	logic [GAIN_BITS-1:0] data_q;

	for (genvar i = 0; i <= PHASE_STEPS; i++) begin : g_entry
		assign gain_tbl[i] = sine_gain(i);
	end

	always_ff @(posedge clk) begin
		data_q <= gain_tbl[addr];
	end

	assign data = data_q;

endmodule

FILE: rtl/epcm_mac.sv
// Shared multiplier with accumulator, rounding and saturation per channel.
`timescale 1ns / 1ps

module epcm_mac import epcm_pkg::*; (
	input  logic                 clk,
	input  mac_ctrl_t            ctrl,
	input  sample_t              smp,
	input  logic [GAIN_BITS-1:0] gain,
	output sample_t              res [CHANNELS]
);

	localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int ACC_BITS  = PROD_BITS + 1;
	localparam int SHIFT     = GAIN_BITS - 1;

	localparam logic signed [ACC_BITS-1:0] SatMax =
		{{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] SatMin =
		{{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [ACC_BITS-1:0] RoundHalf = ACC_BITS'(1) <<< (SHIFT - 1);

	logic signed [PROD_BITS-1:0] smp_x;
	logic signed [PROD_BITS-1:0] gain_x;
	logic signed [PROD_BITS-1:0] prod_s1;
	logic signed [PROD_BITS-1:0] acc_q;
	logic signed [ACC_BITS-1:0]  total;
	logic signed [ACC_BITS-1:0]  scaled;
	sample_t                     sat_val;
	sample_t                     res_q [CHANNELS];

	assign smp_x  = PROD_BITS'(smp);
	assign gain_x = PROD_BITS'($signed({1'b0, gain}));

	// Rounds half up: add half an LSB, then shift arithmetically.
	assign total  = ACC_BITS'(acc_q) + ACC_BITS'(prod_s1) + RoundHalf;
	assign scaled = total >>> SHIFT;

	always_comb begin
		if (scaled > SatMax) begin
			sat_val = SatMax[SAMPLE_BITS-1:0];
		end else if (scaled < SatMin) begin
			sat_val = SatMin[SAMPLE_BITS-1:0];
		end else begin
			sat_val = scaled[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= smp_x * gain_x;
		end
		if (ctrl.acc_first) begin
			acc_q <= prod_s1;
		end
		if (ctrl.acc_last) begin
			res_q[ctrl.ch] <= sat_val;
		end
	end

	assign res = res_q;

endmodule
